FILE: hdl/ook_pulse_pair_decoder_defines.svh
// ----------------------------------------------------------------------------
// ook pulse pair decoder assertion macros
// shared concurrent assertion forms, sampled on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef OOK_PULSE_PAIR_DECODER_DEFINES_SVH
`define OOK_PULSE_PAIR_DECODER_DEFINES_SVH

// condition holds at every edge outside reset
`define OPPD_ASSERT_HOLDS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// condition at one edge implies another at the next edge
`define OPPD_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/oppd_pkg.sv
// ----------------------------------------------------------------------------
// oppd_pkg
// shared types, register codes and reset values of the pulse pair decoder
// ----------------------------------------------------------------------------
package oppd_pkg;

   localparam int MAX_FRAME_BITS_DEF = 64;
   localparam int WIDTH_BITS_DEF     = 16;

   // frame length registers are fixed at 7 bits
   localparam int LEN_REG_W   = 7;
   localparam int CSR_INDEX_W = 3;

   localparam int MIN_FRAME_BITS_RESET  = 24;
   localparam int MAX_FRAME_BITS_RESET  = 64;
   localparam int SHORT_MIN_WIDTH_RESET = 200;
   localparam int LONG_MIN_WIDTH_RESET  = 600;
   localparam int LONG_MAX_WIDTH_RESET  = 1500;

   typedef enum logic [1:0] {
      PULSE_INVALID = 2'd0,
      PULSE_SHORT   = 2'd1,
      PULSE_LONG    = 2'd2
   } pulse_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_FRAME_BITS  = 3'd0,
      CSR_MAX_FRAME_BITS  = 3'd1,
      CSR_SHORT_MIN_WIDTH = 3'd2,
      CSR_LONG_MIN_WIDTH  = 3'd3,
      CSR_LONG_MAX_WIDTH  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [LEN_REG_W-1:0] min_bits;
      logic [LEN_REG_W-1:0] max_bits;
   } frame_limits_type;

endpackage

FILE: hdl/oppd_csr.sv
// ----------------------------------------------------------------------------
// oppd_csr
// configuration registers: frame length limits and pulse width thresholds
// ----------------------------------------------------------------------------
module oppd_csr
   import oppd_pkg::*;
#(
   parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WIDTH_BITS-1:0]  csr_wdata,
   output frame_limits_type       limits,
   output logic [WIDTH_BITS-1:0]  short_floor,
   output logic [WIDTH_BITS-1:0]  long_floor,
   output logic [WIDTH_BITS-1:0]  long_ceiling
);

   frame_limits_type      limits_ff,       limits_in;
   logic [WIDTH_BITS-1:0] short_floor_ff,  short_floor_in;
   logic [WIDTH_BITS-1:0] long_floor_ff,   long_floor_in;
   logic [WIDTH_BITS-1:0] long_ceiling_ff, long_ceiling_in;

   always_comb begin
      limits_in       = limits_ff;
      short_floor_in  = short_floor_ff;
      long_floor_in   = long_floor_ff;
      long_ceiling_in = long_ceiling_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_FRAME_BITS:  limits_in.min_bits = csr_wdata[LEN_REG_W-1:0];
            CSR_MAX_FRAME_BITS:  limits_in.max_bits = csr_wdata[LEN_REG_W-1:0];
            CSR_SHORT_MIN_WIDTH: short_floor_in  = csr_wdata;
            CSR_LONG_MIN_WIDTH:  long_floor_in   = csr_wdata;
            CSR_LONG_MAX_WIDTH:  long_ceiling_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.min_bits <= LEN_REG_W'(MIN_FRAME_BITS_RESET);
         limits_ff.max_bits <= LEN_REG_W'(MAX_FRAME_BITS_RESET);
         short_floor_ff     <= WIDTH_BITS'(SHORT_MIN_WIDTH_RESET);
         long_floor_ff      <= WIDTH_BITS'(LONG_MIN_WIDTH_RESET);
         long_ceiling_ff    <= WIDTH_BITS'(LONG_MAX_WIDTH_RESET);
      end else begin
         limits_ff       <= limits_in;
         short_floor_ff  <= short_floor_in;
         long_floor_ff   <= long_floor_in;
         long_ceiling_ff <= long_ceiling_in;
      end
   end

   assign limits       = limits_ff;
   assign short_floor  = short_floor_ff;
   assign long_floor   = long_floor_ff;
   assign long_ceiling = long_ceiling_ff;

endmodule

FILE: hdl/oppd_classify.sv
// ----------------------------------------------------------------------------
// oppd_classify
// sorts one pulse width into short, long or invalid
// ----------------------------------------------------------------------------
module oppd_classify
   import oppd_pkg::*;
#(
   parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
   input  logic [WIDTH_BITS-1:0] pulse_width,
   input  logic [WIDTH_BITS-1:0] short_floor,
   input  logic [WIDTH_BITS-1:0] long_floor,
   input  logic [WIDTH_BITS-1:0] long_ceiling,
   output pulse_kind_type        kind
);

   // tests applied in fixed order, even with thresholds out of order
   always_comb begin
      if (pulse_width < short_floor) begin
         kind = PULSE_INVALID;
      end else if (pulse_width < long_floor) begin
         kind = PULSE_SHORT;
      end else if (pulse_width <= long_ceiling) begin
         kind = PULSE_LONG;
      end else begin
         kind = PULSE_INVALID;
      end
   end

endmodule

FILE: hdl/oppd_frame.sv
// ----------------------------------------------------------------------------
// oppd_frame
// pulse pairing state, bit collection and frame emit decision
// ----------------------------------------------------------------------------
`include "ook_pulse_pair_decoder_defines.svh"

module oppd_frame
   import oppd_pkg::*;
#(
   parameter int MAX_FRAME_BITS = MAX_FRAME_BITS_DEF,
   parameter int CNT_W          = $clog2(MAX_FRAME_BITS + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  pulse_kind_type            kind,
   input  frame_limits_type          limits,
   output logic                      emit,
   output logic [MAX_FRAME_BITS-1:0] emit_bits,
   output logic [CNT_W-1:0]          emit_length
);

   localparam int IDX_W = (MAX_FRAME_BITS > 1) ? $clog2(MAX_FRAME_BITS) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_FRAME_BITS);

   pulse_kind_type            prev_ff,  prev_in;
   logic                      half_ff,  half_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [MAX_FRAME_BITS-1:0] store_ff, store_in;

   logic [CNT_W-1:0]          count_inc;
   logic [MAX_FRAME_BITS-1:0] store_set;
   logic                      frame_full;

   always_comb begin
      count_inc  = count_ff + CNT_W'(1);
      store_set  = store_ff;
      if (prev_ff == PULSE_LONG) begin
         store_set[count_ff[IDX_W-1:0]] = 1'b1;
      end
      frame_full = (LEN_REG_W'(count_inc) == limits.max_bits) || (count_inc == FULL_COUNT);
   end

   always_comb begin
      prev_in     = prev_ff;
      half_in     = half_ff;
      count_in    = count_ff;
      store_in    = store_ff;
      emit        = 1'b0;
      emit_bits   = store_ff;
      emit_length = count_ff;
      if (step) begin
         prev_in = kind;
         if (prev_ff == PULSE_INVALID) begin
            // frame ended by an invalid pulse
            emit     = (LEN_REG_W'(count_ff) >= limits.min_bits);
            half_in  = 1'b0;
            count_in = '0;
            store_in = '0;
         end else if (half_ff && (prev_ff != kind)) begin
            // pair complete, commit one bit
            emit_bits   = store_set;
            emit_length = count_inc;
            half_in     = 1'b0;
            if (frame_full) begin
               emit     = 1'b1;
               count_in = '0;
               store_in = '0;
            end else begin
               count_in = count_inc;
               store_in = store_set;
            end
         end else begin
            half_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= PULSE_INVALID;
         half_ff  <= 1'b0;
         count_ff <= '0;
         store_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         half_ff  <= half_in;
         count_ff <= count_in;
         store_ff <= store_in;
      end
   end

   `OPPD_ASSERT_HOLDS(a_count_in_range, count_ff < FULL_COUNT, "bit count reached capacity")
   `OPPD_ASSERT_NEXT(a_clear_after_emit, step && emit, (count_ff == '0) && (store_ff == '0), "frame not cleared after emit")
   `OPPD_ASSERT_NEXT(a_invalid_ends_pair, step && (prev_ff == PULSE_INVALID), !half_ff && (count_ff == '0), "frame not restarted after invalid pulse")

endmodule

FILE: hdl/ook_pulse_pair_decoder.sv
// ----------------------------------------------------------------------------
// ook_pulse_pair_decoder
// on-off-keying pulse width decoder: pairs of pulses to bits, bits to frames
// ----------------------------------------------------------------------------
// One transaction on req_ carries a measured pulse width. It is registered,
// classified as short, long or invalid against the three width thresholds,
// and folded into the frame state once the result register is free or being
// emptied. Two consecutive pulses of differing kind commit one bit (long
// gives 1, short gives 0), the first bit landing in bit 0. An invalid pulse
// ends the frame, which is sent on rsp_ if it holds at least min_frame_bits
// bits; a frame reaching max_frame_bits (or capacity) is sent at once. A new
// transaction is taken every cycle in which req_stall is low; req_stall
// rises only while a finished frame waits on rsp_stall and the registered
// pulse still has to be folded in. A pulse gives at most one frame. The user
// must write configuration registers only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module ook_pulse_pair_decoder
   import oppd_pkg::*;
#(
   parameter int MAX_FRAME_BITS = MAX_FRAME_BITS_DEF,
   parameter int WIDTH_BITS     = WIDTH_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // pulse transactions
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [WIDTH_BITS-1:0]                   req_pulse_width,
   // frame transactions
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [MAX_FRAME_BITS-1:0]               rsp_frame_bits,
   output logic [$clog2(MAX_FRAME_BITS + 1)-1:0]   rsp_frame_length,
   // configuration writes
   input  logic                                    csr_write,
   input  logic [CSR_INDEX_W-1:0]                  csr_index,
   input  logic [WIDTH_BITS-1:0]                   csr_wdata
);

   localparam int CNT_W = $clog2(MAX_FRAME_BITS + 1);

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [WIDTH_BITS-1:0] pulse_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [MAX_FRAME_BITS-1:0] rsp_bits_ff;
   logic [CNT_W-1:0]          rsp_length_ff;

   frame_limits_type      limits;
   logic [WIDTH_BITS-1:0] short_floor;
   logic [WIDTH_BITS-1:0] long_floor;
   logic [WIDTH_BITS-1:0] long_ceiling;

   pulse_kind_type            kind;
   logic                      advance;
   logic                      req_take;
   logic                      emit;
   logic [MAX_FRAME_BITS-1:0] emit_bits;
   logic [CNT_W-1:0]          emit_length;

   oppd_csr #(
      .WIDTH_BITS (WIDTH_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .limits       (limits),
      .short_floor  (short_floor),
      .long_floor   (long_floor),
      .long_ceiling (long_ceiling)
   );

   oppd_classify #(
      .WIDTH_BITS (WIDTH_BITS)
   ) u_classify (
      .pulse_width  (pulse_ff),
      .short_floor  (short_floor),
      .long_floor   (long_floor),
      .long_ceiling (long_ceiling),
      .kind         (kind)
   );

   oppd_frame #(
      .MAX_FRAME_BITS (MAX_FRAME_BITS),
      .CNT_W          (CNT_W)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .kind        (kind),
      .limits      (limits),
      .emit        (emit),
      .emit_bits   (emit_bits),
      .emit_length (emit_length)
   );

   // the registered pulse moves on whenever the result register is free
   // or being emptied this cycle, so every pulse is safe to fold in
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         pulse_ff <= req_pulse_width;
      end
      if (advance && emit) begin
         rsp_bits_ff   <= emit_bits;
         rsp_length_ff <= emit_length;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_bits   = rsp_bits_ff;
   assign rsp_frame_length = rsp_length_ff;

endmodule
